// File: design/rid_pkg.sv
// ----------------------------------------------------------------------------
// rid_pkg: shared types and constants of the restoring integer divider
// Holds the operand width, the input and result word layouts, the controller
// states and the command bundle passed from the controller to the datapath.
// ----------------------------------------------------------------------------
package rid_pkg;

  // Width of the arithmetic inside the divider.
  localparam int DATA_WIDTH = 32;
  // Fixed width of the operand and result fields on the ports.
  localparam int FIELD_W    = 32;
  // Width of the step counter.
  localparam int CNT_W      = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef struct packed {
    logic [FIELD_W-1:0] dividend;
    logic [FIELD_W-1:0] divisor;
  } in_word_t;

  typedef struct packed {
    logic [FIELD_W-1:0] quotient;
    logic [FIELD_W-1:0] remainder;
    logic               divide_by_zero;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

endpackage

// File: design/rid_ctrl.sv
// ----------------------------------------------------------------------------
// rid_ctrl: controller of the restoring integer divider
// Sequences a load and DATA_WIDTH quotient steps, then presents the
// result for a single cycle.
// ----------------------------------------------------------------------------
module rid_ctrl
  import rid_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  output logic    out_valid,
  output dp_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;
  cnt_t   cnt_r;
  cnt_t   cnt_nxt;
  logic   accept;

  // A new word may be taken while the previous result is being shown.
  assign accept = start && (state_r != ST_CALC);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE, ST_DONE: begin
        if (accept) begin
          state_nxt = ST_CALC;
          cnt_nxt   = CNT_W'(DATA_WIDTH - 1);
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CALC: begin
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r - cnt_t'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.load  = 1'b0;
    cmd.step  = 1'b0;
    busy      = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cmd.load = accept;
      end
      ST_CALC: begin
        cmd.step = 1'b1;
        busy     = 1'b1;
      end
      ST_DONE: begin
        cmd.load  = accept;
        out_valid = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// File: design/rid_dpath.sv
// ----------------------------------------------------------------------------
// rid_dpath: datapath of the restoring integer divider
// Holds the partial remainder, the divisor and a combined dividend/quotient
// shift register, and performs one trial subtraction per step.
// ----------------------------------------------------------------------------
module rid_dpath
  import rid_pkg::*;
(
  input  logic      clk,
  input  dp_cmd_t   cmd,
  input  in_word_t  in_data,
  output out_word_t out_data
);

  data_t                quo_r;
  data_t                quo_nxt;
  data_t                rem_r;
  data_t                rem_nxt;
  data_t                dvs_r;
  logic                 dbz_r;
  logic [DATA_WIDTH:0]  shifted;
  logic [DATA_WIDTH+1:0] diff;
  logic                 fits;
  data_t                dvd_in;
  data_t                dvs_in;

  assign dvd_in = data_t'(in_data.dividend);
  assign dvs_in = data_t'(in_data.divisor);

  // Bring down the next dividend bit and try to subtract the divisor. The
  // top bit of the difference is the borrow: clear means the divisor fits.
  // A zero divisor always fits, which leaves all ones in the quotient and the
  // dividend in the remainder, exactly the values flagged for that case.
  assign shifted = {rem_r, quo_r[DATA_WIDTH-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};
  assign fits    = ~diff[DATA_WIDTH+1];

  always_comb begin
    rem_nxt = fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
    quo_nxt = {quo_r[DATA_WIDTH-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo_r <= dvd_in;
      rem_r <= '0;
      dvs_r <= dvs_in;
      dbz_r <= (dvs_in == '0);
    end else if (cmd.step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign out_data.quotient       = FIELD_W'(quo_r);
  assign out_data.remainder      = FIELD_W'(rem_r);
  assign out_data.divide_by_zero = dbz_r;

endmodule

// File: design/restoring_integer_divider_top.sv
// ----------------------------------------------------------------------------
// restoring_integer_divider_top: unsigned radix-2 restoring divider
// Operation: a word taken at one edge is loaded, then divided in 32 quotient
//   steps; its result is shown on out_data for one cycle.
// The step loop through the single subtractor takes no new word while a
//   division runs; a new word may start in the result cycle.
// Reset: synchronous, active low; returns the controller to idle.
// The receiver cannot stall and must take every result in the cycle shown.
// ----------------------------------------------------------------------------
module restoring_integer_divider_top
  import rid_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_data,
  output logic      out_valid,
  output out_word_t out_data
);

  // The controller owns the step count and the handshake; the datapath only
  // follows its load and step commands. The operands are sampled in the load
  // cycle, so in_data need not be held once the word has been taken.
  dp_cmd_t cmd;

  rid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // One trial subtraction per step. A zero divisor needs no special path:
  // the subtraction always succeeds, giving an all-ones quotient and the
  // dividend as remainder, and the flag is captured at load.
  rid_dpath u_dpath (
    .clk      (clk),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

  // The result strobe lasts a single cycle.
  a_strobe_single : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // An accepted word always starts a division.
  a_accept_starts : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted word did not start a division");

  // A flagged zero divisor reports an all-ones quotient.
  a_dbz_quotient : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.divide_by_zero) |->
      (out_data.quotient == FIELD_W'({DATA_WIDTH{1'b1}})))
    else $error("zero divisor did not give an all-ones quotient");

endmodule
